### rtl/core/assert_macros.svh
// assertion helpers used by lru_recency_list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lrl_pkg.sv
package lrl_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_BUMP      = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_LEFT,
    OP_FROM_RIGHT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic     cmp_en;
    logic     slot_valid;
    cell_op_e op;
  } cell_ctrl_t;

endpackage

### rtl/core/lrl_cell.sv
module lrl_cell #(
  parameter int TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrl_pkg::cell_ctrl_t ctrl_i,
  input  logic [TAG_BITS-1:0] cmp_tag_i,
  input  logic [TAG_BITS-1:0] load_tag_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  input  logic                hit_i,
  output logic [TAG_BITS-1:0] tag_o,
  output logic                hit_o
);

  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                match_q;

  always_comb begin
    tag_d = tag_q;
    case (ctrl_i.op)
      lrl_pkg::OP_LOAD:       tag_d = load_tag_i;
      lrl_pkg::OP_FROM_LEFT:  tag_d = left_tag_i;
      lrl_pkg::OP_FROM_RIGHT: tag_d = right_tag_i;
      default:                tag_d = tag_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  // compare against the request tag when it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= ctrl_i.slot_valid && (tag_q == cmp_tag_i);
    end
  end

  assign tag_o = tag_q;
  assign hit_o = hit_i | match_q;

endmodule

### rtl/core/lru_recency_list.sv
// channel   | direction | signals                                 | handshake
// ----------+-----------+-----------------------------------------+-------------------------
// request   | in        | command_i, tag_i                        | start && !busy
// result    | out       | status_o, entry_count_o, is_empty_o,    | done_o, one cycle
//           |           | is_full_o, front_tag_o, back_tag_o      |
// config    | in        | cfg_data_i (max_entries)                | cfg_valid_i && cfg_ready_o
//
// a request runs in steps: compare in every cell at the accept edge, shift the cell
// chain in UPDATE, then collect front and back tags into the result registers in REPORT
// the result shows in the cycle after that, while the next request may already be taken
// busy is high in the UPDATE and REPORT states after accept
// reset clears the count and control; tag cells are not cleared, only counted slots are read
// results cannot be stalled; cfg_ready_o is always high
`include "assert_macros.svh"

module lru_recency_list #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lrl_pkg::CMD_W-1:0]       command_i,
  input  logic [lrl_pkg::FIELD_W-1:0]     tag_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrl_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            done_o,
  output logic [lrl_pkg::STATUS_W-1:0]    status_o,
  output logic [lrl_pkg::COUNT_W-1:0]     entry_count_o,
  output logic                            is_empty_o,
  output logic                            is_full_o,
  output logic [lrl_pkg::FIELD_W-1:0]     front_tag_o,
  output logic [lrl_pkg::FIELD_W-1:0]     back_tag_o
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > lrl_pkg::CFG_W) ? OCC_W : lrl_pkg::CFG_W;
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(DEPTH);

  lrl_pkg::state_e              state_q, state_d;
  logic [lrl_pkg::CMD_W-1:0]    cmd_q;
  logic [TAG_BITS-1:0]          req_tag_q;
  logic [OCC_W-1:0]             occ_q, occ_d;
  logic [lrl_pkg::STATUS_W-1:0] stat_q, stat_d;
  logic [lrl_pkg::CFG_W-1:0]    max_q;
  logic                         accept;
  logic                         at_cap;
  logic                         found;

  logic [TAG_BITS-1:0]          slot_tag [DEPTH];
  logic [DEPTH:0]               hit;
  lrl_pkg::cell_ctrl_t          ctrl [DEPTH];
  logic [TAG_BITS-1:0]          back_tag;

  logic                         done_q;
  logic [lrl_pkg::STATUS_W-1:0] status_q;
  logic [lrl_pkg::COUNT_W-1:0]  count_q;
  logic                         empty_q, full_q;
  logic [lrl_pkg::FIELD_W-1:0]  front_q, back_q;

  assign accept      = start && !busy;
  assign busy        = (state_q != lrl_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign at_cap      = (occ_q == OCC_MAX);
  assign found       = hit[DEPTH];
  assign hit[0]      = 1'b0;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [OCC_W-1:0] IDX     = OCC_W'(i);
    localparam logic [OCC_W:0]   IDX_NXT = (OCC_W + 1)'(i + 1);
    logic [TAG_BITS-1:0] left_tag, right_tag;
    lrl_pkg::cell_op_e   op;

    assign left_tag  = (i == 0) ? req_tag_q : slot_tag[(i == 0) ? 0 : i - 1];
    assign right_tag = (i == DEPTH - 1) ? slot_tag[i] : slot_tag[(i == DEPTH - 1) ? i : i + 1];

    always_comb begin
      op = lrl_pkg::OP_HOLD;
      if (state_q == lrl_pkg::ST_UPDATE) begin
        case (cmd_q)
          lrl_pkg::CMD_INS_FRONT: begin
            if (!at_cap) begin
              if (i == 0) begin
                op = lrl_pkg::OP_LOAD;
              end else if (IDX <= occ_q) begin
                op = lrl_pkg::OP_FROM_LEFT;
              end
            end
          end
          lrl_pkg::CMD_INS_BACK: begin
            if (!at_cap && (IDX == occ_q)) begin
              op = lrl_pkg::OP_LOAD;
            end
          end
          lrl_pkg::CMD_REM_FRONT: begin
            if (IDX_NXT < {1'b0, occ_q}) begin
              op = lrl_pkg::OP_FROM_RIGHT;
            end
          end
          lrl_pkg::CMD_BUMP: begin
            if (found) begin
              if (i == 0) begin
                op = lrl_pkg::OP_LOAD;
              end else if (!hit[i]) begin
                op = lrl_pkg::OP_FROM_LEFT;
              end
            end
          end
          default: op = lrl_pkg::OP_HOLD;
        endcase
      end
    end

    assign ctrl[i].cmp_en     = accept;
    assign ctrl[i].slot_valid = (IDX < occ_q);
    assign ctrl[i].op         = op;

    lrl_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[i]),
      .cmp_tag_i  (TAG_BITS'(tag_i)),
      .load_tag_i (req_tag_q),
      .left_tag_i (left_tag),
      .right_tag_i(right_tag),
      .hit_i      (hit[i]),
      .tag_o      (slot_tag[i]),
      .hit_o      (hit[i+1])
    );
  end

  // last valid slot
  always_comb begin
    back_tag = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((OCC_W + 1)'(i + 1) == {1'b0, occ_q}) begin
        back_tag = back_tag | slot_tag[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    stat_d  = stat_q;
    case (state_q)
      lrl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lrl_pkg::ST_UPDATE;
        end
      end
      lrl_pkg::ST_UPDATE: begin
        state_d = lrl_pkg::ST_REPORT;
        stat_d  = lrl_pkg::STAT_OK;
        case (cmd_q)
          lrl_pkg::CMD_INS_FRONT, lrl_pkg::CMD_INS_BACK: begin
            if (at_cap) begin
              stat_d = lrl_pkg::STAT_OVERFLOW;
            end else begin
              occ_d = occ_q + OCC_W'(1);
            end
          end
          lrl_pkg::CMD_REM_FRONT, lrl_pkg::CMD_REM_BACK: begin
            if (occ_q != '0) begin
              occ_d = occ_q - OCC_W'(1);
            end
          end
          lrl_pkg::CMD_BUMP: begin
            if (occ_q == '0) begin
              stat_d = lrl_pkg::STAT_EMPTY;
            end else if (!found) begin
              stat_d = lrl_pkg::STAT_NOT_FOUND;
            end
          end
          default: stat_d = lrl_pkg::STAT_OK;
        endcase
      end
      lrl_pkg::ST_REPORT: begin
        state_d = lrl_pkg::ST_IDLE;
      end
      default: state_d = lrl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrl_pkg::ST_IDLE;
      occ_q   <= '0;
      max_q   <= lrl_pkg::MAX_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= (state_q == lrl_pkg::ST_REPORT);
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    if (accept) begin
      cmd_q     <= command_i;
      req_tag_q <= TAG_BITS'(tag_i);
    end
    if (state_q == lrl_pkg::ST_REPORT) begin
      status_q <= stat_q;
      count_q  <= lrl_pkg::COUNT_W'(occ_q);
      empty_q  <= (occ_q == '0);
      full_q   <= (CMP_W'(occ_q) == CMP_W'(max_q));
      front_q  <= (occ_q == '0) ? '0 : lrl_pkg::FIELD_W'(slot_tag[0]);
      back_q   <= (occ_q == '0) ? '0 : lrl_pkg::FIELD_W'(back_tag);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;
  assign front_tag_o   = front_q;
  assign back_tag_o    = back_q;

  `ASSERT_IMPLIES(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OCC_MAX, "count above depth")
  `ASSERT_NEXT(a_accept_update, clk_i, rst_ni, accept, state_q == lrl_pkg::ST_UPDATE, "no update after accept")
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `ASSERT_IMPLIES(a_overflow_full, clk_i, rst_ni, (state_q == lrl_pkg::ST_REPORT) && (stat_q == lrl_pkg::STAT_OVERFLOW), occ_q == OCC_MAX, "overflow below capacity")
  `ASSERT_IMPLIES(a_empty_status, clk_i, rst_ni, done_o && (status_o == lrl_pkg::STAT_EMPTY), is_empty_o, "empty status on nonempty list")

endmodule

### bench/recency_checker.sv
module recency_checker #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [lrl_pkg::CMD_W-1:0]     command_i,
  input  logic [lrl_pkg::FIELD_W-1:0]   tag_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [lrl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          done_o,
  input  logic [lrl_pkg::STATUS_W-1:0]  status_o,
  input  logic [lrl_pkg::COUNT_W-1:0]   entry_count_o,
  input  logic                          is_empty_o,
  input  logic                          is_full_o,
  input  logic [lrl_pkg::FIELD_W-1:0]   front_tag_o,
  input  logic [lrl_pkg::FIELD_W-1:0]   back_tag_o,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import lrl_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
    logic                 full;
    logic [FIELD_W-1:0]   front;
    logic [FIELD_W-1:0]   back;
  } list_report_t;

  logic [FIELD_W-1:0] slots [DEPTH];
  int                 held;
  logic [CFG_W-1:0]   max_entries;
  list_report_t       expected_reports [$];

  // move slots 0..upto-1 one place toward the back
  function automatic void push_back_from(int upto);
    for (int i = upto; i > 0; i--) slots[i] = slots[i-1];
  endfunction

  function automatic list_report_t apply_command(logic [CMD_W-1:0] cmd,
                                                 logic [FIELD_W-1:0] tag);
    list_report_t rep;
    int           hit;
    rep.status = STAT_OK;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (held >= DEPTH) begin
          rep.status = STAT_OVERFLOW;
        end else if (cmd == CMD_INS_FRONT) begin
          push_back_from(held);
          slots[0] = tag;
          held++;
        end else begin
          slots[held] = tag;
          held++;
        end
      end
      CMD_REM_FRONT: begin
        if (held > 0) begin
          for (int i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
          held--;
        end
      end
      CMD_REM_BACK: begin
        if (held > 0) held--;
      end
      CMD_BUMP: begin
        if (held == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          hit = held;
          for (int i = held - 1; i >= 0; i--) if (slots[i] == tag) hit = i;
          if (hit == held) begin
            rep.status = STAT_NOT_FOUND;
          end else begin
            push_back_from(hit);
            slots[0] = tag;
          end
        end
      end
      default: begin
      end
    endcase
    rep.count = COUNT_W'(held);
    rep.empty = (held == 0);
    rep.full  = (COUNT_W'(held) == max_entries);
    rep.front = (held > 0) ? slots[0] : '0;
    rep.back  = (held > 0) ? slots[held-1] : '0;
    return rep;
  endfunction

  always @(posedge clk_i) begin : watch
    list_report_t want;
    if (!rst_ni) begin
      held        = 0;
      max_entries = MAX_RESET;
      expected_reports.delete();
      fail_count  = 0;
      pending     = 0;
      checked     = 0;
    end else begin
      if (done_o) begin
        if (expected_reports.size() == 0) begin
          if (fail_count < SHOWN_MISMATCHES)
            $display("%0t: report with nothing outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (status_o !== want.status || entry_count_o !== want.count ||
              is_empty_o !== want.empty || is_full_o !== want.full ||
              front_tag_o !== want.front || back_tag_o !== want.back) begin
            if (fail_count < SHOWN_MISMATCHES)
              $display("%0t: mismatch, expected status %0d count %0d empty %b full %b",
                       $realtime, want.status, want.count, want.empty, want.full,
                       " front %h back %h / got status %0d count %0d empty %b full %b",
                       want.front, want.back, status_o, entry_count_o, is_empty_o,
                       is_full_o, " front %h back %h", front_tag_o, back_tag_o);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) max_entries = cfg_data_i;
      if (start && !busy) expected_reports.push_back(apply_command(command_i, tag_i));
      pending = expected_reports.size();
    end
  end

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrl_pkg::*;

  localparam int DEPTH          = 16;
  localparam int TAG_BITS       = 32;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 125;
  localparam int POOL_SIZE      = 6;
  localparam int MAX_GAP        = 11;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command_i;
  logic [FIELD_W-1:0]  tag_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                is_empty_o;
  logic                is_full_o;
  logic [FIELD_W-1:0]  front_tag_o;
  logic [FIELD_W-1:0]  back_tag_o;

  int chk_fails;
  int chk_pending;
  int chk_checked;

  int                 requests_sent;
  int                 settings_written;
  int                 burst_left;
  logic [FIELD_W-1:0] tag_pool [POOL_SIZE];
  logic [CFG_W-1:0]   phase_max [PHASES];

  lru_recency_list #(
    .DEPTH   (DEPTH),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .tag_i        (tag_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .front_tag_o  (front_tag_o),
    .back_tag_o   (back_tag_o)
  );

  recency_checker #(
    .DEPTH(DEPTH)
  ) recency_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .tag_i        (tag_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .front_tag_o  (front_tag_o),
    .back_tag_o   (back_tag_o),
    .fail_count   (chk_fails),
    .pending      (chk_pending),
    .checked      (chk_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] tag);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     = 1'b1;
    command_i = cmd;
    tag_i     = tag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_max_entries(input logic [CFG_W-1:0] value);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    settings_written++;
  endtask

  function automatic logic [CMD_W-1:0] pick_command(int insert_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if (roll < 4 + insert_pct) return $urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT;
    if (roll < 32 + insert_pct) return CMD_BUMP;
    return $urandom_range(0, 1) ? CMD_REM_BACK : CMD_REM_FRONT;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_tag();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    start            = 1'b0;
    command_i        = CMD_INS_FRONT;
    tag_i            = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    rst_ni           = 1'b0;
    requests_sent    = 0;
    settings_written = 0;
    burst_left       = 0;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
    phase_max = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd0};
    phase_max[PHASES-1] = CFG_W'($urandom_range(0, 31));
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty list, extremes, duplicates, full below capacity, overflow
    write_max_entries(5'd4);
    send_request(CMD_BUMP, 32'h0000_0000);
    send_request(CMD_REM_FRONT, 32'hFFFF_FFFF);
    send_request(CMD_REM_BACK, 32'h0000_0000);
    send_request(CMD_INS_FRONT, 32'h0000_0000);
    send_request(CMD_INS_BACK, 32'hFFFF_FFFF);
    send_request(CMD_INS_FRONT, 32'hA5A5_A5A5);
    send_request(CMD_INS_BACK, 32'h5A5A_5A5A);
    send_request(CMD_INS_FRONT, 32'hA5A5_A5A5);
    send_request(CMD_BUMP, 32'h1234_5678);
    send_request(CMD_BUMP, 32'hA5A5_A5A5);
    send_request(CMD_BUMP, 32'h5A5A_5A5A);
    send_request(CMD_BUMP, 32'hA5A5_A5A5);
    send_request(CMD_SPARE_HI, 32'hFFFF_FFFF);
    for (int i = 5; i < DEPTH; i++)
      send_request((i % 2) ? CMD_INS_BACK : CMD_INS_FRONT, $urandom);
    send_request(CMD_INS_FRONT, 32'hFFFF_FFFF);
    send_request(CMD_INS_BACK, 32'h0000_0000);

    // random phases, alternating filling and draining pressure
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_max_entries(phase_max[p]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        cmd = pick_command((p % 2) ? 22 : 45);
        if ((cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK) && $urandom_range(0, 5) == 0)
          tag_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        send_request(cmd, pick_tag());
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d requests under %0d max_entries settings, %0d reports compared",
             requests_sent, settings_written, chk_checked);
    $display("every command incl. no-op codes, overflow, empty and duplicate-tag bumps");
    if (chk_fails == 0 && chk_pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
